// ===== design/reseed_request_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Reseed request tracker assertion macros
// Shared property wrappers for the tracker's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RESEED_REQUEST_TRACKER_DEFINES_SVH
`define RESEED_REQUEST_TRACKER_DEFINES_SVH

// Same-cycle implication, held off while reset is high
`define RRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is high
`define RRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Reseed request tracker package
// Recovery phase codes, control state grouping and default widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rrt_pkg;

  // Default generation / counter width
  localparam int unsigned RRT_GEN_WIDTH = 32;

  // Width of the generation and counter fields on the ports
  localparam int unsigned RRT_PORT_WIDTH = 32;

  // Item kinds
  localparam logic ACT_OBSERVE = 1'b0;
  localparam logic ACT_ROLLOUT = 1'b1;

  // Recovery phase
  typedef enum logic [1:0] {
    PH_HEALTHY        = 2'd0,
    PH_RESEED_PENDING = 2'd1,
    PH_AWAIT_RESULT   = 2'd2,
    PH_AWAIT_ROUTE    = 2'd3
  } rrt_phase_t;

  // Recovery control state
  typedef struct packed {
    rrt_phase_t phase;
    logic       reseed_flag;
  } rrt_ctrl_t;

  // Per-beat request flags
  typedef struct packed {
    logic reseed_requested;
    logic replan_requested;
  } rrt_flags_t;

endpackage

`default_nettype wire

// ===== design/rrt_update.sv =====
// ----------------------------------------------------------------------------
// Reseed request tracker update logic
// Works out the next tracker state and the request flags for one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_update #(
  parameter int unsigned GEN_WIDTH = rrt_pkg::RRT_GEN_WIDTH
) (
  input  wire logic                 action,
  input  wire logic [GEN_WIDTH-1:0] route_gen,
  input  wire logic [GEN_WIDTH-1:0] local_live_gen,
  input  wire logic [GEN_WIDTH-1:0] route_live_gen,
  input  wire logic [GEN_WIDTH-1:0] maneuver_gen,
  input  wire logic                 rollout_available,
  input  wire logic                 was_reseeded,
  input  wire logic [GEN_WIDTH-1:0] last_route_gen,
  input  wire logic [GEN_WIDTH-1:0] last_local_live_gen,
  input  wire logic [GEN_WIDTH-1:0] last_route_live_gen,
  input  wire logic [GEN_WIDTH-1:0] last_maneuver_gen,
  input  wire logic [GEN_WIDTH-1:0] reseed_cnt,
  input  wire logic [GEN_WIDTH-1:0] recovery_cnt,
  input  wire rrt_pkg::rrt_ctrl_t   ctrl,
  output logic                      gens_load,
  output logic [GEN_WIDTH-1:0]      reseed_cnt_next,
  output logic [GEN_WIDTH-1:0]      recovery_cnt_next,
  output rrt_pkg::rrt_ctrl_t        ctrl_next,
  output rrt_pkg::rrt_flags_t       flags
);

  import rrt_pkg::*;

  logic route_moved;
  logic pending;
  logic obs_req;

  // Change detection against the stored generations
  assign route_moved = (route_gen != '0) && (route_gen != last_route_gen);
  assign pending     = (ctrl.phase == PH_RESEED_PENDING);
  assign obs_req     = route_moved
                    || (local_live_gen > last_local_live_gen)
                    || (route_live_gen > last_route_live_gen)
                    || (maneuver_gen > last_maneuver_gen)
                    || pending;

  // Phase, counter and flag update
  always_comb begin
    gens_load         = 1'b0;
    reseed_cnt_next   = reseed_cnt;
    recovery_cnt_next = recovery_cnt;
    ctrl_next         = ctrl;
    flags             = '0;
    if (action == ACT_OBSERVE) begin
      gens_load              = 1'b1;
      flags.reseed_requested = obs_req;
      if (obs_req) begin
        reseed_cnt_next       = reseed_cnt + GEN_WIDTH'(1);
        ctrl_next.reseed_flag = 1'b0;
        if (pending && ctrl.reseed_flag && !route_moved) begin
          ctrl_next.phase = PH_AWAIT_ROUTE;
        end else if (ctrl.phase != PH_HEALTHY) begin
          ctrl_next.phase = PH_AWAIT_RESULT;
        end
      end
    end else if (rollout_available) begin
      ctrl_next.phase       = PH_HEALTHY;
      ctrl_next.reseed_flag = 1'b0;
    end else if (ctrl.phase == PH_HEALTHY) begin
      recovery_cnt_next = recovery_cnt + GEN_WIDTH'(1);
      ctrl_next.phase   = PH_RESEED_PENDING;
    end else if ((ctrl.phase == PH_AWAIT_RESULT) && was_reseeded) begin
      recovery_cnt_next      = recovery_cnt + GEN_WIDTH'(1);
      ctrl_next.phase        = PH_RESEED_PENDING;
      ctrl_next.reseed_flag  = 1'b1;
      flags.replan_requested = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/reseed_request_tracker.sv =====
// ----------------------------------------------------------------------------
// Reseed request tracker
// Raises reseed requests from planner generation numbers and tracks the
// recovery phase after rollouts that had no eligible candidate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per item: action 0
//   is a generation observation, action 1 a rollout result. Output channel
//   (out_valid / out_stall) returns exactly one beat per item with both
//   counters and the phase after the item, plus the request flags.
//   An accepted beat passes from the input register through the update
//   logic into the result register, which raises out_valid. Throughput is
//   one item per cycle while out_stall is low; the tracker state lives in
//   single registers updated as a beat moves into the result register, so
//   the next item sees it.
//   Reset (rst, synchronous) clears the stored generations, both counters
//   and the reseed flag, and puts the phase back to healthy.
//   While out_stall holds a result, the input register still takes one more
//   beat; in_stall rises only once both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "reseed_request_tracker_defines.svh"

module reseed_request_tracker #(
  parameter int unsigned GEN_WIDTH = rrt_pkg::RRT_GEN_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [31:0] route_gen,
  input  wire logic [31:0] local_live_gen,
  input  wire logic [31:0] route_live_gen,
  input  wire logic [31:0] maneuver_gen,
  input  wire logic        rollout_available,
  input  wire logic        was_reseeded,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      reseed_count,
  output logic [31:0]      recovery_count,
  output logic [1:0]       phase,
  output logic             reseed_requested,
  output logic             replan_requested
);

  import rrt_pkg::*;

  // Input register
  logic                 s1_valid;
  logic                 s1_action;
  logic [GEN_WIDTH-1:0] s1_route_gen;
  logic [GEN_WIDTH-1:0] s1_local_live_gen;
  logic [GEN_WIDTH-1:0] s1_route_live_gen;
  logic [GEN_WIDTH-1:0] s1_maneuver_gen;
  logic                 s1_avail;
  logic                 s1_reseeded;

  // Tracker state
  logic [GEN_WIDTH-1:0] last_route_gen;
  logic [GEN_WIDTH-1:0] last_local_live_gen;
  logic [GEN_WIDTH-1:0] last_route_live_gen;
  logic [GEN_WIDTH-1:0] last_maneuver_gen;
  logic [GEN_WIDTH-1:0] reseed_cnt;
  logic [GEN_WIDTH-1:0] recovery_cnt;
  rrt_ctrl_t            ctrl;

  // Update results
  logic                 gens_load;
  logic [GEN_WIDTH-1:0] reseed_cnt_next;
  logic [GEN_WIDTH-1:0] recovery_cnt_next;
  rrt_ctrl_t            ctrl_next;
  rrt_flags_t           flags;

  logic advance;
  logic s1_load;

  // Handshake: beat moves on when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign s1_load  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_action         <= action;
      s1_route_gen      <= GEN_WIDTH'(route_gen);
      s1_local_live_gen <= GEN_WIDTH'(local_live_gen);
      s1_route_live_gen <= GEN_WIDTH'(route_live_gen);
      s1_maneuver_gen   <= GEN_WIDTH'(maneuver_gen);
      s1_avail          <= rollout_available;
      s1_reseeded       <= was_reseeded;
    end
  end

  // Next-state and flag logic
  rrt_update #(
    .GEN_WIDTH(GEN_WIDTH)
  ) u_update (
    .action              (s1_action),
    .route_gen           (s1_route_gen),
    .local_live_gen      (s1_local_live_gen),
    .route_live_gen      (s1_route_live_gen),
    .maneuver_gen        (s1_maneuver_gen),
    .rollout_available   (s1_avail),
    .was_reseeded        (s1_reseeded),
    .last_route_gen      (last_route_gen),
    .last_local_live_gen (last_local_live_gen),
    .last_route_live_gen (last_route_live_gen),
    .last_maneuver_gen   (last_maneuver_gen),
    .reseed_cnt          (reseed_cnt),
    .recovery_cnt        (recovery_cnt),
    .ctrl                (ctrl),
    .gens_load           (gens_load),
    .reseed_cnt_next     (reseed_cnt_next),
    .recovery_cnt_next   (recovery_cnt_next),
    .ctrl_next           (ctrl_next),
    .flags               (flags)
  );

  // Tracker state, committed as a beat leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_route_gen      <= '0;
      last_local_live_gen <= '0;
      last_route_live_gen <= '0;
      last_maneuver_gen   <= '0;
      reseed_cnt          <= '0;
      recovery_cnt        <= '0;
      ctrl                <= '{phase: PH_HEALTHY, reseed_flag: 1'b0};
    end else if (advance) begin
      if (gens_load) begin
        last_route_gen      <= s1_route_gen;
        last_local_live_gen <= s1_local_live_gen;
        last_route_live_gen <= s1_route_live_gen;
        last_maneuver_gen   <= s1_maneuver_gen;
      end
      reseed_cnt   <= reseed_cnt_next;
      recovery_cnt <= recovery_cnt_next;
      ctrl         <= ctrl_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      reseed_count     <= RRT_PORT_WIDTH'(reseed_cnt_next);
      recovery_count   <= RRT_PORT_WIDTH'(recovery_cnt_next);
      phase            <= ctrl_next.phase;
      reseed_requested <= flags.reseed_requested;
      replan_requested <= flags.replan_requested;
    end
  end

  // Checks
  `RRT_ASSERT_SAME(a_flags_exclusive, out_valid && reseed_requested, !replan_requested, "two requests")
  `RRT_ASSERT_SAME(a_replan_phase, out_valid && replan_requested, phase == PH_RESEED_PENDING, "replan phase")
  `RRT_ASSERT_NEXT(a_recovery_hold, !advance, $stable(recovery_cnt), "recovery count moved")
  `RRT_ASSERT_NEXT(a_reseed_hold, !(advance && flags.reseed_requested), $stable(reseed_cnt), "reseed count moved")

endmodule

`default_nettype wire
